/* rtl/cfs_pkg.sv */
// Package for the camera follow scroll update block.
// Holds field widths, register indexes, easing constants and the config struct.
// No dependencies; every other file of the block imports it.
package cfs_pkg;

   // Field widths
   localparam int MODE_W   = 16;
   localparam int COORD_W  = 32;
   localparam int POS_W    = 20;
   localparam int EXTENT_W = 16;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 16;

   // Signed working width for step math (32-bit difference plus headroom)
   localparam int WIDE_W   = 34;

   // Object modes that let the cameras follow
   localparam logic [MODE_W-1:0] MODE_FOLLOW_IDLE  = 16'd0;
   localparam logic [MODE_W-1:0] MODE_FOLLOW_CHASE = 16'd6;

   // Target offsets (screen center), applied modulo 2^32
   localparam logic [COORD_W-1:0] OFFSET_X = 32'hFFFF_8800;
   localparam logic [COORD_W-1:0] OFFSET_Y = 32'hFFFF_B000;

   // Map edge margins in blocks
   localparam logic [EXTENT_W-1:0] MARGIN_X = 16'd30;
   localparam logic [EXTENT_W-1:0] MARGIN_Y = 16'd20;

   // Register indexes on the configuration channel
   localparam logic [ADDR_W-1:0] REG_WRAP_MODE     = 3'd0;
   localparam logic [ADDR_W-1:0] REG_MAP_WIDTH     = 3'd1;
   localparam logic [ADDR_W-1:0] REG_MAP_HEIGHT    = 3'd2;
   localparam logic [ADDR_W-1:0] REG_MAIN_ENABLE   = 3'd3;
   localparam logic [ADDR_W-1:0] REG_SECOND_ENABLE = 3'd4;

   typedef struct packed {
      logic                wrap_mode;
      logic [EXTENT_W-1:0] map_width_blocks;
      logic [EXTENT_W-1:0] map_height_blocks;
      logic                main_layer_enable;
      logic                second_layer_enable;
   } cfg_type;

endpackage

/* rtl/cfs_if.sv */
// Channel interfaces for the camera follow scroll update block.
// Request, response and configuration-write channels; depends on cfs_pkg.
interface cfs_req_if;
   import cfs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         object_mode;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   modport source (output valid, object_mode, target_x, target_y, input ready);
   modport sink   (input valid, object_mode, target_x, target_y, output ready);
endinterface

interface cfs_rsp_if;
   import cfs_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] main_x;
   logic [POS_W-1:0] main_y;
   logic [POS_W-1:0] second_x;
   logic [POS_W-1:0] second_y;
   logic             applied;
   modport source (output valid, main_x, main_y, second_x, second_y, applied, input ready);
   modport sink   (input valid, main_x, main_y, second_x, second_y, applied, output ready);
endinterface

interface cfs_csr_if;
   import cfs_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

/* rtl/camera_follow_scroll_update_top.sv */
// Top level of the camera follow scroll update block.
// Instantiates cfs_csr and two cfs_axis units; depends on cfs_pkg and cfs_if.
//
// Usage:
//   req_ch carries one transaction per tracked-object sample: object_mode and
//   the signed target X/Y. rsp_ch returns one transaction per request with the
//   main and second layer camera positions after the step, plus the applied
//   flag (set for modes 0 and 6). csr_ch writes the configuration registers by
//   index (0 wrap_mode, 1 map width, 2 map height, 3 main enable, 4 second
//   enable); it is always ready and should be written only while idle.
//   A request is held in the input register, then its result in the output
//   register. Throughput: one transaction per cycle unless rsp_ch stalls;
//   the camera state is written in the same cycle the result is registered,
//   so the next request sees it at once.
//   A stalled rsp_ch holds the output register; the input register still
//   fills, and req_ch.ready drops only when both are full.
//   Reset clears the cameras to 0, wrap_mode to 1, other registers to 0 and
//   empties both pipeline registers.
module camera_follow_scroll_update_top (
   input  logic      clock,
   input  logic      reset,
   cfs_req_if.sink   req_ch,
   cfs_rsp_if.source rsp_ch,
   cfs_csr_if.sink   csr_ch
);
   import cfs_pkg::*;

   cfg_type cfg;

   // Input register
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [MODE_W-1:0]         s1_mode_ff;
   logic signed [COORD_W-1:0] s1_x_ff;
   logic signed [COORD_W-1:0] s1_y_ff;

   // Camera state
   logic [POS_W-1:0] main_x_ff, main_x_in;
   logic [POS_W-1:0] main_y_ff, main_y_in;
   logic [POS_W-1:0] sec_x_ff,  sec_x_in;
   logic [POS_W-1:0] sec_y_ff,  sec_y_in;

   // Output register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [POS_W-1:0] rsp_main_x_ff;
   logic [POS_W-1:0] rsp_main_y_ff;
   logic [POS_W-1:0] rsp_sec_x_ff;
   logic [POS_W-1:0] rsp_sec_y_ff;
   logic             rsp_applied_ff;

   logic             req_take;
   logic             advance;
   logic             applied;
   logic [POS_W-1:0] step_x;
   logic [POS_W-1:0] step_y;

   cfs_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   cfs_axis u_axis_x (
      .target    (s1_x_ff),
      .offset    (OFFSET_X),
      .cam       (main_x_ff),
      .extent    (cfg.map_width_blocks),
      .margin    (MARGIN_X),
      .wrap_mode (cfg.wrap_mode),
      .step      (step_x)
   );

   cfs_axis u_axis_y (
      .target    (s1_y_ff),
      .offset    (OFFSET_Y),
      .cam       (main_y_ff),
      .extent    (cfg.map_height_blocks),
      .margin    (MARGIN_Y),
      .wrap_mode (cfg.wrap_mode),
      .step      (step_y)
   );

   // Handshake: stage 1 moves when the output register is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   // Camera update
   assign applied = (s1_mode_ff == MODE_FOLLOW_IDLE) || (s1_mode_ff == MODE_FOLLOW_CHASE);

   always_comb begin
      main_x_in = main_x_ff;
      main_y_in = main_y_ff;
      sec_x_in  = sec_x_ff;
      sec_y_in  = sec_y_ff;
      if (advance && applied) begin
         if (cfg.main_layer_enable) begin
            main_x_in = main_x_ff + step_x;
            main_y_in = main_y_ff + step_y;
         end
         if (cfg.second_layer_enable) begin
            sec_x_in = sec_x_ff + step_x;
            sec_y_in = sec_y_ff + step_y;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         main_x_ff    <= '0;
         main_y_ff    <= '0;
         sec_x_ff     <= '0;
         sec_y_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         main_x_ff    <= main_x_in;
         main_y_ff    <= main_y_in;
         sec_x_ff     <= sec_x_in;
         sec_y_ff     <= sec_y_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_ch.object_mode;
         s1_x_ff    <= req_ch.target_x;
         s1_y_ff    <= req_ch.target_y;
      end
      if (advance) begin
         rsp_main_x_ff  <= main_x_in;
         rsp_main_y_ff  <= main_y_in;
         rsp_sec_x_ff   <= sec_x_in;
         rsp_sec_y_ff   <= sec_y_in;
         rsp_applied_ff <= applied;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.main_x   = rsp_main_x_ff;
   assign rsp_ch.main_y   = rsp_main_y_ff;
   assign rsp_ch.second_x = rsp_sec_x_ff;
   assign rsp_ch.second_y = rsp_sec_y_ff;
   assign rsp_ch.applied  = rsp_applied_ff;

endmodule

/* rtl/cfs_csr.sv */
// Configuration registers of the camera follow scroll update block.
// Decodes writes from the CSR channel into cfg_type; depends on cfs_pkg, cfs_if.
module cfs_csr (
   input  logic             clock,
   input  logic             reset,
   cfs_csr_if.sink          csr_ch,
   output cfs_pkg::cfg_type cfg
);
   import cfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Always ready; writes should happen only while the block is idle, which the block itself does not enforce
   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_ch.addr)
            REG_WRAP_MODE:     cfg_in.wrap_mode           = csr_ch.wdata[0];
            REG_MAP_WIDTH:     cfg_in.map_width_blocks    = csr_ch.wdata;
            REG_MAP_HEIGHT:    cfg_in.map_height_blocks   = csr_ch.wdata;
            REG_MAIN_ENABLE:   cfg_in.main_layer_enable   = csr_ch.wdata[0];
            REG_SECOND_ENABLE: cfg_in.second_layer_enable = csr_ch.wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_mode           <= 1'b1;
         cfg_ff.map_width_blocks    <= '0;
         cfg_ff.map_height_blocks   <= '0;
         cfg_ff.main_layer_enable   <= 1'b0;
         cfg_ff.second_layer_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/cfs_axis.sv */
// Easing step for one axis: offset, camera difference, divide by 8, fold or clamp.
// Purely combinational; depends on cfs_pkg.
module cfs_axis (
   input  logic signed [cfs_pkg::COORD_W-1:0]  target,
   input  logic        [cfs_pkg::COORD_W-1:0]  offset,
   input  logic        [cfs_pkg::POS_W-1:0]    cam,
   input  logic        [cfs_pkg::EXTENT_W-1:0] extent,
   input  logic        [cfs_pkg::EXTENT_W-1:0] margin,
   input  logic                                wrap_mode,
   output logic        [cfs_pkg::POS_W-1:0]    step
);
   import cfs_pkg::*;

   localparam logic signed [WIDE_W-1:0] FOLD_LIMIT = WIDE_W'(2048);

   logic        [COORD_W-1:0] diff;
   logic signed [WIDE_W-1:0]  diff_w;
   logic signed [WIDE_W-1:0]  d;
   logic signed [WIDE_W-1:0]  fold;
   logic signed [WIDE_W-1:0]  lo;
   logic signed [WIDE_W-1:0]  span;
   logic signed [WIDE_W-1:0]  hi_num;
   logic signed [WIDE_W-1:0]  hi;
   logic signed [WIDE_W-1:0]  d_out;

   // Divide by 8 rounding toward zero
   function automatic logic signed [WIDE_W-1:0] trunc8(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] adj;
      adj = v + (v[WIDE_W-1] ? WIDE_W'(7) : WIDE_W'(0));
      return adj >>> 3;
   endfunction

   // Difference wraps modulo 2^32 before the divide
   assign diff   = COORD_W'(target) + offset - COORD_W'(cam);
   assign diff_w = WIDE_W'(signed'(diff));
   assign d      = trunc8(diff_w);

   // Fold amount and clamp bounds
   assign fold   = signed'(WIDE_W'({extent, 8'b0}));
   assign lo     = WIDE_W'(0) - WIDE_W'(cam[POS_W-1:3]);
   assign span   = WIDE_W'(extent) - WIDE_W'(margin);
   assign hi_num = (span <<< 11) - WIDE_W'(cam);
   assign hi     = trunc8(hi_num);

   // Wrap fold or map clamp
   always_comb begin
      d_out = d;
      if (wrap_mode) begin
         if (d < -FOLD_LIMIT) begin
            d_out = d + fold;
         end else if (d > FOLD_LIMIT) begin
            d_out = d - fold;
         end
      end else if (d < 0) begin
         if (d < lo) begin
            d_out = lo;
         end
      end else if (d > 0) begin
         if (d > hi) begin
            d_out = hi;
         end
      end
   end

   // Positions are kept modulo 2^20, so only the low bits matter
   assign step = d_out[POS_W-1:0];

endmodule

/* test/cfs_checker.sv */
`timescale 1ns / 100ps
// Checker for the camera follow scroll update block: watches all three channels.
// Predicts each response from its own camera state and config copy; uses cfs_pkg and cfs_if.
module cfs_checker (
   input  logic clock,
   input  logic reset,
   cfs_req_if   req_mon,
   cfs_rsp_if   rsp_mon,
   cfs_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);
   import cfs_pkg::*;

   localparam longint FOLD_LIMIT  = 2048;
   localparam longint FOLD_SCALE  = 256;
   localparam longint BLOCK_STEPS = 2048;
   localparam longint EASE_DIV    = 8;

   typedef struct packed {
      logic [POS_W-1:0] main_x;
      logic [POS_W-1:0] main_y;
      logic [POS_W-1:0] second_x;
      logic [POS_W-1:0] second_y;
      logic             applied;
   } cam_view_type;

   cfg_type          setup;
   logic [POS_W-1:0] main_x, main_y, second_x, second_y;
   cam_view_type     expected_views[$];

   // Easing step along one axis: wrap the difference to 32 bits, divide, then
   // fold around the map or clamp the main camera into it.
   function automatic longint ease_step(input logic [COORD_W-1:0] target,
                                        input logic [COORD_W-1:0] offset,
                                        input logic [POS_W-1:0] cam,
                                        input logic [EXTENT_W-1:0] extent,
                                        input longint margin,
                                        input logic wrap);
      logic [COORD_W-1:0] gap;
      longint step, span, cam_l, bound;
      gap   = target + offset - {{(COORD_W-POS_W){1'b0}}, cam};
      step  = $signed(gap);
      step  = step / EASE_DIV;
      span  = extent;
      cam_l = cam;
      if (wrap) begin
         if (step < -FOLD_LIMIT)
            step += span * FOLD_SCALE;
         else if (step > FOLD_LIMIT)
            step -= span * FOLD_SCALE;
      end else if (step < 0) begin
         bound = (-cam_l) / EASE_DIV;
         if (step < bound)
            step = bound;
      end else if (step > 0) begin
         bound = ((span - margin) * BLOCK_STEPS - cam_l) / EASE_DIV;
         if (step > bound)
            step = bound;
      end
      return step;
   endfunction

   task automatic check_field(input string name, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got, inout int errs);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      cam_view_type want;
      longint       dx, dy;
      int           errs;
      errs = 0;
      if (reset) begin
         setup = '{wrap_mode: 1'b1, default: '0};
         main_x = '0;
         main_y = '0;
         second_x = '0;
         second_y = '0;
         expected_views.delete();
         fail_count <= 0;
      end else begin
         // config write transaction
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               REG_WRAP_MODE:     setup.wrap_mode           = csr_mon.wdata[0];
               REG_MAP_WIDTH:     setup.map_width_blocks    = csr_mon.wdata;
               REG_MAP_HEIGHT:    setup.map_height_blocks   = csr_mon.wdata;
               REG_MAIN_ENABLE:   setup.main_layer_enable   = csr_mon.wdata[0];
               REG_SECOND_ENABLE: setup.second_layer_enable = csr_mon.wdata[0];
               default: ;
            endcase
         end

         // response transaction against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_views.size() == 0) begin
               $error("response transaction with no request outstanding");
               errs++;
            end else begin
               want = expected_views.pop_front();
               check_field("main_x", want.main_x, rsp_mon.main_x, errs);
               check_field("main_y", want.main_y, rsp_mon.main_y, errs);
               check_field("second_x", want.second_x, rsp_mon.second_x, errs);
               check_field("second_y", want.second_y, rsp_mon.second_y, errs);
               check_field("applied", POS_W'(want.applied), POS_W'(rsp_mon.applied), errs);
            end
         end

         // request transaction: advance the cameras and record the view
         if (req_mon.valid && req_mon.ready) begin
            want.applied = (req_mon.object_mode == MODE_FOLLOW_IDLE) ||
                           (req_mon.object_mode == MODE_FOLLOW_CHASE);
            if (want.applied) begin
               dx = ease_step(req_mon.target_x, OFFSET_X, main_x,
                              setup.map_width_blocks, MARGIN_X, setup.wrap_mode);
               dy = ease_step(req_mon.target_y, OFFSET_Y, main_y,
                              setup.map_height_blocks, MARGIN_Y, setup.wrap_mode);
               if (setup.main_layer_enable) begin
                  main_x = main_x + dx[POS_W-1:0];
                  main_y = main_y + dy[POS_W-1:0];
               end
               if (setup.second_layer_enable) begin
                  second_x = second_x + dx[POS_W-1:0];
                  second_y = second_y + dy[POS_W-1:0];
               end
            end
            want.main_x   = main_x;
            want.main_y   = main_y;
            want.second_x = second_x;
            want.second_y = second_y;
            expected_views.push_back(want);
         end
         fail_count <= fail_count + errs;
      end
      pending <= expected_views.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for camera_follow_scroll_update_top: clock, reset, stimulus, verdict.
// Depends on cfs_pkg, cfs_if, the block itself and cfs_checker.
module tb_top;
   import cfs_pkg::*;

   localparam logic [ADDR_W-1:0] REG_UNMAPPED = REG_SECOND_ENABLE + 3'd1;
   localparam int PHASES          = 11;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int HOLD_CYCLES     = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   snd_idle_pct = 36;
   int   rcv_idle_pct = 84;
   int   hold_reqs    = 0;

   cfs_req_if req_ch();
   cfs_rsp_if rsp_ch();
   cfs_csr_if csr_ch();

   camera_follow_scroll_update_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfs_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // run limit
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: random back-pressure plus an occasional long hold-off
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   function automatic cfg_type make_setup(input logic wrap, input int width, input int height,
                                          input logic main_en, input logic second_en);
      cfg_type c;
      c.wrap_mode           = wrap;
      c.map_width_blocks    = EXTENT_W'(width);
      c.map_height_blocks   = EXTENT_W'(height);
      c.main_layer_enable   = main_en;
      c.second_layer_enable = second_en;
      return c;
   endfunction

   // mostly small maps so clamping bites inside the 20-bit camera range
   function automatic int pick_extent();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 65535);
      return $urandom_range(0, 600);
   endfunction

   function automatic cfg_type pick_setup(input int ph);
      case (ph)
         0:       return make_setup(1'b1, 0, 0, 1'b1, 1'b1);
         1:       return make_setup(1'b0, 542, 532, 1'b1, 1'b1);
         2:       return make_setup(1'b0, 0, 0, 1'b1, 1'b0);
         3:       return make_setup(1'b1, 65535, 65535, 1'b1, 1'b1);
         4:       return make_setup(1'b0, 65535, 65535, 1'b1, 1'b1);
         5:       return make_setup(1'b1, 4096, 4096, 1'b1, 1'b1);
         6:       return make_setup(1'b0, 30, 20, 1'b1, 1'b1);
         7:       return make_setup(1'($urandom_range(0, 1)), pick_extent(), pick_extent(),
                                    1'b0, 1'b1);
         default: return make_setup(1'($urandom_range(0, 1)), pick_extent(), pick_extent(),
                                    $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return MODE_FOLLOW_IDLE;
         4, 5, 6:    return MODE_FOLLOW_CHASE;
         7:          return MODE_W'($urandom_range(1, 7));
         default:    return MODE_W'($urandom());
      endcase
   endfunction

   // targets mostly near the camera area, spread over many step sizes
   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] center);
      int span_bits;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            span_bits = $urandom_range(3, 24);
            return center + $urandom_range(0, (1 << POS_W) - 1) +
                   ($urandom_range(0, 1 << span_bits) - (1 << (span_bits - 1)));
         end
      endcase
   endfunction

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.object_mode = mode;
      req_ch.target_x    = x;
      req_ch.target_y    = y;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering and wait until every response has come back
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.addr  = addr;
      csr_ch.wdata = data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // write every register, junk in the unused bits of the one-bit ones
   task automatic apply_setup(input cfg_type c);
      quiesce();
      csr_write(REG_WRAP_MODE, {15'($urandom()), c.wrap_mode});
      csr_write(REG_MAP_WIDTH, c.map_width_blocks);
      csr_write(REG_MAP_HEIGHT, c.map_height_blocks);
      csr_write(REG_MAIN_ENABLE, {15'($urandom()), c.main_layer_enable});
      csr_write(REG_SECOND_ENABLE, {15'($urandom()), c.second_layer_enable});
      csr_write(REG_UNMAPPED + ADDR_W'($urandom_range(0, 2)), DATA_W'($urandom()));
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.object_mode = '0;
      req_ch.target_x    = '0;
      req_ch.target_y    = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.addr        = '0;
      csr_ch.wdata       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset config: layers disabled, modes on and off the follow list
      send_item(MODE_FOLLOW_IDLE, 32'h0000_7800, 32'h0000_5000);
      send_item(MODE_FOLLOW_CHASE, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(MODE_W'(7), 32'h0000_0000, 32'h0000_0000);
      send_item(MODE_W'(16'hFFFF), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_W'(1), 32'h1234_5678, 32'h8765_4321);

      // clamp: zero step, negative clamp, positive clamp, wrapped difference
      apply_setup(make_setup(1'b0, 40, 25, 1'b1, 1'b1));
      send_item(MODE_FOLLOW_IDLE, 32'h0000_7800, 32'h0000_5000);
      send_item(MODE_FOLLOW_IDLE, 32'h0000_6800, 32'h0000_4000);
      send_item(MODE_FOLLOW_CHASE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(MODE_FOLLOW_IDLE, 32'h8000_0000, 32'h8000_0000);
      send_item(MODE_FOLLOW_IDLE, 32'h0000_0000, 32'h0000_0000);

      // wrap folds in both directions, main layer only
      apply_setup(make_setup(1'b1, 16, 16, 1'b1, 1'b0));
      send_item(MODE_FOLLOW_IDLE, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(MODE_FOLLOW_CHASE, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(MODE_FOLLOW_CHASE, 32'h0000_7800, 32'h0000_5000);
      send_item(MODE_W'(2), 32'h0000_7800, 32'h0000_5000);

      // map smaller than the margin: upper clamp bound goes negative
      apply_setup(make_setup(1'b0, 0, 0, 1'b0, 1'b1));
      send_item(MODE_FOLLOW_IDLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(MODE_FOLLOW_IDLE, 32'h8000_0000, 32'h8000_0000);
      send_item(MODE_FOLLOW_CHASE, 32'h0000_0000, 32'h0000_0000);

      // largest map
      apply_setup(make_setup(1'b0, 65535, 65535, 1'b1, 1'b1));
      send_item(MODE_FOLLOW_IDLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(MODE_FOLLOW_CHASE, 32'h8000_0000, 32'hFFFF_FFFF);

      // random phases, each under its own config, in three idle mixes
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) begin
            snd_idle_pct = 36;
            rcv_idle_pct = 84;
         end else if (ph < 8) begin
            snd_idle_pct = 84;
            rcv_idle_pct = 36;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         apply_setup(pick_setup(ph));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((ph == 8 && n == 20) || (ph == 2 && n == 30))
               hold_reqs++;
            if (ph == 9 && n == 50)
               quiesce();
            send_item(pick_mode(), pick_coord(-OFFSET_X), pick_coord(-OFFSET_Y));
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
